/* rtl/sgsma_pkg.sv */
// ----------------------------------------------------------------------------
// sgsma_pkg
// Shared widths, register indexes and constants for the sample conditioning
// block (gain, square forcing, moving average).
// ----------------------------------------------------------------------------
`default_nettype none

package sgsma_pkg;

	// window depth of the moving average store
	localparam int MAX_PERIOD = 64;
	localparam int POS_W      = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;

	localparam int RAW_W     = 16;
	localparam int MODE_W    = 2;
	localparam int PER_W     = 7;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int RES_W     = 24;
	// raw sample plus offset
	localparam int X_W       = 18;
	// magnitudes of gain, offset sample and full scale
	localparam int MAG_W     = 17;
	localparam int PROD_W    = 2 * MAG_W;
	// running sum of up to MAX_PERIOD results
	localparam int SUM_W     = RES_W + $clog2(MAX_PERIOD + 1);
	// compare width for position wrap
	localparam int CMP_W     = (PER_W > POS_W + 1) ? PER_W : POS_W + 1;

	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DC     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SQUARE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd4;

	localparam logic [MODE_W-1:0] MODE_8BIT = 2'd1;

	localparam logic [MODE_W-1:0] RST_MODE = MODE_8BIT;
	localparam logic [CFG_W-1:0]  RST_GAIN = 16'd256;

	localparam logic [MAG_W-1:0] FULL_SCALE_8  = 17'h0007f;
	localparam logic [MAG_W-1:0] FULL_SCALE_16 = 17'h07fff;

	typedef logic [RAW_W-1:0]        raw_t;
	typedef logic signed [RES_W-1:0] res_t;

endpackage

`default_nettype wire

/* rtl/sgsma_in_if.sv */
// ----------------------------------------------------------------------------
// sgsma_in_if
// Input sample channel: valid/ready with raw sample and history clear flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface sgsma_in_if;
	import sgsma_pkg::*;

	logic valid;
	logic ready;
	raw_t raw_sample;
	logic clear_history;

	modport source (output valid, output raw_sample, output clear_history, input ready);
	modport sink   (input valid, input raw_sample, input clear_history, output ready);
endinterface

`default_nettype wire

/* rtl/sgsma_out_if.sv */
// ----------------------------------------------------------------------------
// sgsma_out_if
// Output sample channel: valid/ready with the conditioned sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface sgsma_out_if;
	import sgsma_pkg::*;

	logic valid;
	logic ready;
	res_t out_sample;

	modport source (output valid, output out_sample, input ready);
	modport sink   (input valid, input out_sample, output ready);
endinterface

`default_nettype wire

/* rtl/sgsma_ram.sv */
// ----------------------------------------------------------------------------
// sgsma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sgsma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/sgsma_mul.sv */
// ----------------------------------------------------------------------------
// sgsma_mul
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sgsma_mul import sgsma_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [MAG_W-1:0]  a,
	input  wire logic [MAG_W-1:0]  b,
	output logic                   done,
	output logic      [PROD_W-1:0] prod
);

	localparam int CNT_W = $clog2(MAG_W + 1);

	logic [MAG_W-1:0]  a_q;
	logic [PROD_W-1:0] acc_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [MAG_W:0]    add;
	logic [PROD_W-1:0] step;

	// upper half accumulates, lower half holds the multiplier bits still to go
	always_comb begin
		add  = {1'b0, acc_q[PROD_W-1:MAG_W]} + (acc_q[0] ? {1'b0, a_q} : '0);
		step = {add, acc_q[MAG_W-1:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(MAG_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			acc_q <= {{MAG_W{1'b0}}, b};
		end else if (busy_q) begin
			acc_q <= step;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

`default_nettype wire

/* rtl/sgsma_div.sv */
// ----------------------------------------------------------------------------
// sgsma_div
// Bit-serial restoring divider: running sum magnitude over window length,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sgsma_div import sgsma_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [SUM_W-1:0] dividend,
	input  wire logic [PER_W-1:0] divisor,
	output logic                  done,
	output logic      [SUM_W-1:0] quotient
);

	localparam int CNT_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0] quo_q;
	logic [PER_W-1:0] rem_q;
	logic [PER_W-1:0] d_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [PER_W:0]   trial;
	logic             ge;
	logic [PER_W-1:0] rem_next;

	always_comb begin
		trial    = {rem_q, quo_q[SUM_W-1]};
		ge       = (trial >= {1'b0, d_q});
		rem_next = ge ? PER_W'(trial - {1'b0, d_q}) : trial[PER_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(SUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// dividend shifts out at the top while quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

/* rtl/sample_gain_square_moving_average_top.sv */
// ----------------------------------------------------------------------------
// sample_gain_square_moving_average_top
// PCM sample conditioning: offset, Q8.8 gain, optional square forcing and
// optional moving average over a window of up to MAX_PERIOD samples.
// ----------------------------------------------------------------------------
// One sample is in flight at a time. The 17-step bit-serial multiplier
// makes one pass for the gain and a second in square mode; the 31-step
// bit-serial divider forms the average only when the smoothing period is
// nonzero. A new sample is taken as soon as the previous result sits in
// the output register, even if that result has not been taken yet. Window
// history is cleared at once by valid bits, so there is no clearing pass
// after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_gain_square_moving_average_top import sgsma_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	sgsma_in_if.sink                  sample_in,
	sgsma_out_if.source               sample_out,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PREP  = 4'd1;
	localparam logic [3:0] S_MUL1  = 4'd2;
	localparam logic [3:0] S_MUL2  = 4'd3;
	localparam logic [3:0] S_ADV   = 4'd4;
	localparam logic [3:0] S_SUB   = 4'd5;
	localparam logic [3:0] S_ADD   = 4'd6;
	localparam logic [3:0] S_DIVST = 4'd7;
	localparam logic [3:0] S_DIV   = 4'd8;
	localparam logic [3:0] S_OUT   = 4'd9;

	// configuration
	logic [MODE_W-1:0] mode_q;
	logic [CFG_W-1:0]  dc_q;
	logic [CFG_W-1:0]  gain_q;
	logic              square_q;
	logic [PER_W-1:0]  period_q;

	logic [3:0]            state_q;
	logic [X_W-1:0]        x_q;
	logic                  sign_q;
	logic [RES_W-1:0]      res_q;
	logic [RES_W-1:0]      out_q;
	logic                  out_valid_q;
	logic [SUM_W-1:0]      sum_q;
	logic [POS_W-1:0]      pos_q;
	logic [MAX_PERIOD-1:0] valid_q;

	logic             accept;
	logic             eight;
	logic             hist_clr;
	logic             out_load;
	logic [RAW_W-1:0] raw_val;
	logic [X_W-1:0]   x_d;
	logic [MAG_W-1:0] gain_mag;
	logic [MAG_W-1:0] x_mag;
	logic [MAG_W-1:0] full_scale;
	logic [PER_W-1:0] p_act;
	logic [CMP_W-1:0] pos_inc;
	logic [POS_W-1:0] pos_next;
	logic [15:0]      m16;
	logic [15:0]      s_val;
	logic [RES_W-1:0] m24;
	logic [RES_W-1:0] sq_val;
	logic [RES_W-1:0] old_val;
	logic [SUM_W-1:0] sum_mag;
	logic [RES_W-1:0] q24;
	logic [RES_W-1:0] avg_val;

	logic              mul_start;
	logic [MAG_W-1:0]  mul_b;
	logic              mul_done;
	logic [PROD_W-1:0] mul_prod;
	logic              div_start;
	logic              div_done;
	logic [SUM_W-1:0]  div_quo;
	logic              ram_we;
	logic              ram_re;
	logic [RES_W-1:0]  ram_rdata;

	always_comb begin
		accept   = sample_in.valid && sample_in.ready;
		eight    = (mode_q == MODE_8BIT);
		hist_clr = (accept && sample_in.clear_history)
			|| (cfg_we && (cfg_index == REG_PERIOD));
		out_load = !out_valid_q || sample_out.ready;

		// low byte minus 128 is the byte with its top bit flipped
		raw_val = eight
			? {{8{~sample_in.raw_sample[7]}}, ~sample_in.raw_sample[7],
				sample_in.raw_sample[6:0]}
			: sample_in.raw_sample;
		x_d = {{(X_W-RAW_W){raw_val[RAW_W-1]}}, raw_val}
			+ {{(X_W-CFG_W){dc_q[CFG_W-1]}}, dc_q};

		gain_mag   = gain_q[CFG_W-1] ? MAG_W'(-{gain_q[CFG_W-1], gain_q})
			: {1'b0, gain_q};
		x_mag      = x_q[X_W-1] ? MAG_W'(-x_q) : MAG_W'(x_q);
		full_scale = eight ? FULL_SCALE_8 : FULL_SCALE_16;

		// truncation toward zero: shift the magnitude, then restore the sign
		m16    = mul_prod[8 +: 16];
		s_val  = sign_q ? -m16 : m16;
		m24    = mul_prod[8 +: RES_W];
		sq_val = sign_q ? -m24 : m24;

		p_act    = (int'(period_q) > MAX_PERIOD) ? PER_W'(MAX_PERIOD) : period_q;
		pos_inc  = CMP_W'(pos_q) + CMP_W'(1);
		pos_next = (pos_inc >= CMP_W'(p_act)) ? '0 : POS_W'(pos_inc);

		old_val = valid_q[pos_q] ? ram_rdata : '0;
		sum_mag = sum_q[SUM_W-1] ? -sum_q : sum_q;
		q24     = div_quo[RES_W-1:0];
		avg_val = sum_q[SUM_W-1] ? -q24 : q24;

		mul_start = (state_q == S_PREP)
			|| ((state_q == S_MUL1) && mul_done && square_q);
		mul_b     = (state_q == S_PREP) ? x_mag : full_scale;
		div_start = (state_q == S_DIVST);
		ram_re    = (state_q == S_ADV);
		ram_we    = (state_q == S_SUB);
	end

	assign sample_in.ready   = (state_q == S_IDLE);
	assign sample_out.valid  = out_valid_q;
	assign sample_out.out_sample = out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= RST_MODE;
			dc_q     <= '0;
			gain_q   <= RST_GAIN;
			square_q <= 1'b0;
			period_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:   mode_q   <= cfg_data[MODE_W-1:0];
				REG_DC:     dc_q     <= cfg_data;
				REG_GAIN:   gain_q   <= cfg_data;
				REG_SQUARE: square_q <= cfg_data[0];
				REG_PERIOD: period_q <= cfg_data[PER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer and window history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			sum_q       <= '0;
			pos_q       <= '0;
			valid_q     <= '0;
		end else begin
			if ((state_q == S_OUT) && out_load) begin
				out_valid_q <= 1'b1;
			end else if (sample_out.ready) begin
				out_valid_q <= 1'b0;
			end

			if (hist_clr) begin
				sum_q   <= '0;
				pos_q   <= '0;
				valid_q <= '0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: state_q <= S_MUL1;
				S_MUL1: begin
					if (mul_done) begin
						state_q <= square_q ? S_MUL2 : S_ADV;
					end
				end
				S_MUL2: begin
					if (mul_done) begin
						state_q <= S_ADV;
					end
				end
				S_ADV: begin
					if (p_act == '0) begin
						state_q <= S_OUT;
					end else begin
						pos_q   <= pos_next;
						state_q <= S_SUB;
					end
				end
				S_SUB: begin
					sum_q          <= sum_q - {{(SUM_W-RES_W){old_val[RES_W-1]}}, old_val};
					valid_q[pos_q] <= 1'b1;
					state_q        <= S_ADD;
				end
				S_ADD: begin
					sum_q   <= sum_q + {{(SUM_W-RES_W){res_q[RES_W-1]}}, res_q};
					state_q <= S_DIVST;
				end
				S_DIVST: state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath payload
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= x_d;
		end
		if (state_q == S_PREP) begin
			sign_q <= gain_q[CFG_W-1] ^ x_q[X_W-1];
		end
		if ((state_q == S_MUL1) && mul_done) begin
			// zero counts as positive for the square sign
			sign_q <= s_val[15] ^ gain_q[CFG_W-1];
			res_q  <= {{(RES_W-16){s_val[15]}}, s_val};
		end
		if ((state_q == S_MUL2) && mul_done) begin
			res_q <= sq_val;
		end
		if ((state_q == S_DIV) && div_done) begin
			res_q <= avg_val;
		end
		if ((state_q == S_OUT) && out_load) begin
			out_q <= res_q;
		end
	end

	sgsma_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (gain_mag),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	sgsma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_mag),
		.divisor  (p_act),
		.done     (div_done),
		.quotient (div_quo)
	);

	sgsma_ram #(
		.WIDTH (RES_W),
		.DEPTH (MAX_PERIOD)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pos_q),
		.wdata (res_q),
		.re    (ram_re),
		.raddr (pos_next),
		.rdata (ram_rdata)
	);

`ifndef NO_ASSERTIONS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !sample_in.ready)
		else $error("second transaction accepted while one is in flight");

	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_MUL1 || state_q == S_MUL2))
		else $error("multiplier finished outside a multiply state");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide state");

	a_pos_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(p_act != '0) |-> (int'(pos_q) < int'(p_act)))
		else $error("window position outside the active period");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result presented without sequencer load");
`endif

endmodule

`default_nettype wire

/* verif/tb_sample_gain_square_moving_average_top.sv */
// ----------------------------------------------------------------------------
// tb_sample_gain_square_moving_average_top
// Self-checking bench for the sample conditioning block. A scoreboard class
// mirrors the offset, gain, square forcing and moving average arithmetic and
// queues one expected sample per accepted input. Directed corner items come
// first, then randomized register settings with random sample streams, with
// random stalls on both channels except in the closing stretch.
// ----------------------------------------------------------------------------

module tb_sample_gain_square_moving_average_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sgsma_pkg::*;

	localparam int N_ITEMS        = 1700;
	localparam int CALM_TAIL      = 250;
	localparam int IDLE_MAX       = 19;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 100;
	localparam int REPORT_MAX     = 10;

	// writes to indexes above the last register must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_PERIOD + 3'd1;

	class sample_scoreboard;
		logic [MODE_W-1:0]  width_mode;
		logic signed [15:0] dc_offset;
		logic signed [15:0] gain;
		bit                 square;
		logic [PER_W-1:0]   period;
		int                 window [MAX_PERIOD];
		int unsigned        position;
		int                 running_sum;
		res_t               expected_samples [$];
		int                 mismatches;

		function new();
			width_mode = RST_MODE;
			dc_offset  = '0;
			gain       = RST_GAIN;
			square     = 1'b0;
			period     = '0;
			mismatches = 0;
			clear_window();
		endfunction

		function void clear_window();
			foreach (window[i])
				window[i] = 0;
			position    = 0;
			running_sum = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_MODE:   width_mode = data[MODE_W-1:0];
				REG_DC:     dc_offset  = data;
				REG_GAIN:   gain       = data;
				REG_SQUARE: square     = data[0];
				REG_PERIOD: begin
					period = data[PER_W-1:0];
					clear_window();
				end
				default: ;
			endcase
		endfunction

		// conditions one accepted sample and queues the expected output
		function void note_input(raw_t raw, logic clr);
			bit                 eight;
			longint             x;
			longint             quot;
			longint             cond;
			longint             g;
			longint             full_scale;
			logic signed [15:0] wrapped;
			logic [63:0]        bits;
			int unsigned        p;
			if (clr)
				clear_window();
			eight = (width_mode == MODE_8BIT);
			if (eight)
				x = longint'(raw[7:0]) - 128;
			else
				x = longint'(signed'(raw));
			quot    = (longint'(gain) * (x + longint'(dc_offset))) / 256;
			bits    = quot;
			wrapped = bits[15:0];
			cond    = wrapped;
			if (square) begin
				full_scale = eight ? longint'(FULL_SCALE_8) : longint'(FULL_SCALE_16);
				// zero counts as positive
				g    = (wrapped < 0) ? -longint'(gain) : longint'(gain);
				cond = (g * full_scale) / 256;
			end
			p = (period > MAX_PERIOD) ? MAX_PERIOD : period;
			if (p != 0) begin
				position = position + 1;
				if (position >= p)
					position = 0;
				running_sum      = running_sum - window[position] + int'(cond);
				window[position] = int'(cond);
				cond             = longint'(running_sum) / longint'(p);
			end
			bits = cond;
			expected_samples.push_back(bits[RES_W-1:0]);
		endfunction

		function void check(res_t got);
			res_t want;
			if (expected_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("ERROR: out_sample %0d with no expected sample pending", got);
				return;
			end
			want = expected_samples.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("ERROR: out_sample expected %0d (0x%06h) got %0d (0x%06h)",
						want, want, got, got);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	sgsma_in_if  sample_in ();
	sgsma_out_if sample_out ();

	sample_scoreboard sb;

	bit stalls_on;
	int stall_left;
	int quiet_cycles;
	int sent;

	sample_gain_square_moving_average_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_in  (sample_in),
		.sample_out (sample_out),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// input transactions feed the scoreboard, output transactions are checked
	always @(posedge clk) begin
		if (arst_n && sample_in.valid && sample_in.ready)
			sb.note_input(sample_in.raw_sample, sample_in.clear_history);
		if (arst_n && sample_out.valid && sample_out.ready)
			sb.check(sample_out.out_sample);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_in.valid && sample_in.ready) ||
			    (sample_out.valid && sample_out.ready) || cfg_we)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("ERROR: no transaction for %0d cycles", quiet_cycles);
				$display("sample_gain_square_moving_average_top test failed");
				$finish;
			end
		end
	end

	// result side backpressure in bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left       <= stall_left - 1;
			sample_out.ready <= 1'b0;
		end else if (stalls_on && $urandom_range(0, 9) == 0) begin
			stall_left       <= $urandom_range(1, IDLE_MAX) - 1;
			sample_out.ready <= 1'b0;
		end else begin
			sample_out.ready <= 1'b1;
		end
	end

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// valid stays high between back-to-back items
	task automatic send_sample(raw_t raw, logic clr);
		if (stalls_on && $urandom_range(0, 7) == 0) begin
			sample_in.valid <= 1'b0;
			repeat ($urandom_range(1, IDLE_MAX)) @(negedge clk);
		end
		sample_in.valid         <= 1'b1;
		sample_in.raw_sample    <= raw;
		sample_in.clear_history <= clr;
		do @(posedge clk); while (!sample_in.ready);
		@(negedge clk);
		sent++;
	endtask

	// hold the sender until every queued result has come back
	task automatic drain();
		sample_in.valid <= 1'b0;
		while (sb.expected_samples.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [15:0] pick_word();
		logic [15:0] w;
		case ($urandom_range(0, 5))
			0: begin
				case ($urandom_range(0, 5))
					0: w = 16'h0000;
					1: w = 16'h0001;
					2: w = 16'h0100;
					3: w = 16'h7fff;
					4: w = 16'h8000;
					default: w = 16'hffff;
				endcase
			end
			1: w = 16'($urandom_range(0, 600)) - 16'd300;
			2: w = 16'($urandom_range(64, 1024));
			default: w = 16'($urandom());
		endcase
		return w;
	endfunction

	task automatic directed_part();
		// reset settings: 8-bit offset samples, unity gain, no smoothing
		send_sample(16'h0000, 1'b0);
		send_sample(16'h00ff, 1'b0);
		send_sample(16'h0080, 1'b1);
		send_sample(16'hff7f, 1'b0);
		drain();
		// 16-bit, gain product wraps
		write_cfg(REG_MODE, 16'h0002);
		write_cfg(REG_DC, 16'h7fff);
		write_cfg(REG_GAIN, 16'h8000);
		send_sample(16'h7fff, 1'b0);
		send_sample(16'h8000, 1'b0);
		send_sample(16'h0000, 1'b0);
		drain();
		write_cfg(REG_DC, 16'h8000);
		write_cfg(REG_GAIN, 16'h7fff);
		send_sample(16'h8000, 1'b0);
		send_sample(16'h7fff, 1'b0);
		drain();
		// square forcing, tiny negative gain, zero treated as positive
		write_cfg(REG_DC, 16'h0000);
		write_cfg(REG_GAIN, 16'hffff);
		write_cfg(REG_SQUARE, 16'h0001);
		send_sample(16'h0000, 1'b0);
		send_sample(16'hffff, 1'b0);
		send_sample(16'h0001, 1'b0);
		drain();
		write_cfg(REG_MODE, 16'h0001);
		write_cfg(REG_GAIN, 16'h8000);
		send_sample(16'h0080, 1'b0);
		send_sample(16'h0000, 1'b0);
		drain();
		// width mode 3 behaves as 16-bit; period of one
		write_cfg(REG_SQUARE, 16'h0000);
		write_cfg(REG_GAIN, 16'h0100);
		write_cfg(REG_MODE, 16'h0003);
		write_cfg(REG_PERIOD, 16'h0001);
		send_sample(16'h1234, 1'b0);
		send_sample(16'h8000, 1'b0);
		drain();
		// period above the window depth saturates; width mode 0
		write_cfg(REG_MODE, 16'h0000);
		write_cfg(REG_PERIOD, 16'h007f);
		send_sample(16'h7fff, 1'b0);
		send_sample(16'h7fff, 1'b0);
		send_sample(16'h8000, 1'b1);
		drain();
		// short window with a history clear in the middle
		write_cfg(REG_PERIOD, 16'hff83);
		send_sample(16'h4000, 1'b0);
		send_sample(16'hc000, 1'b0);
		send_sample(16'h0123, 1'b0);
		send_sample(16'h7fff, 1'b1);
		send_sample(16'h8001, 1'b0);
		drain();
	endtask

	task automatic random_settings();
		logic [MODE_W-1:0] mode;
		logic [PER_W-1:0]  per;
		mode = ($urandom_range(0, 3) == 0) ? MODE_W'($urandom()) :
		       ($urandom_range(0, 1) ? MODE_8BIT : MODE_W'(2));
		write_cfg(REG_MODE, {14'($urandom()), mode});
		write_cfg(REG_DC, pick_word());
		write_cfg(REG_GAIN, pick_word());
		write_cfg(REG_SQUARE, {15'($urandom()), 1'($urandom_range(0, 3) == 0)});
		if ($urandom_range(0, 9) < 7) begin
			case ($urandom_range(0, 9))
				0: per = 7'd0;
				1: per = 7'd1;
				2: per = 7'd64;
				3: per = 7'd65;
				4: per = 7'd127;
				5: per = 7'd63;
				default: per = 7'($urandom_range(2, 12));
			endcase
			write_cfg(REG_PERIOD, {9'($urandom()), per});
		end
		if ($urandom_range(0, 7) == 0)
			write_cfg(REG_SPARE + CFG_IDX_W'($urandom_range(0, 2)), 16'($urandom()));
	endtask

	initial begin
		int   n;
		raw_t raw;
		sb                      = new();
		arst_n                  = 1'b0;
		cfg_we                  = 1'b0;
		cfg_index               = REG_MODE;
		cfg_data                = '0;
		sample_in.valid         = 1'b0;
		sample_in.raw_sample    = '0;
		sample_in.clear_history = 1'b0;
		sample_out.ready        = 1'b0;
		stalls_on               = 1'b1;
		stall_left              = 0;
		quiet_cycles            = 0;
		sent                    = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed_part();

		while (sent < N_ITEMS) begin
			random_settings();
			stalls_on = (sent < N_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
			n = $urandom_range(20, 90);
			repeat (n) begin
				if ($urandom_range(0, 3) == 0) begin
					case ($urandom_range(0, 7))
						0: raw = 16'h0000;
						1: raw = 16'h007f;
						2: raw = 16'h0080;
						3: raw = 16'h00ff;
						4: raw = 16'h7fff;
						5: raw = 16'h8000;
						6: raw = 16'hff00;
						default: raw = 16'hffff;
					endcase
				end else begin
					raw = raw_t'($urandom());
				end
				send_sample(raw, $urandom_range(0, 23) == 0);
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.expected_samples.size() != 0)
			$display("ERROR: %0d expected samples never arrived", sb.expected_samples.size());
		if (sb.mismatches == 0 && sb.expected_samples.size() == 0) begin
			$display("sample_gain_square_moving_average_top test passed");
		end else begin
			$display("sample_gain_square_moving_average_top test failed");
		end
		$finish;
	end

endmodule

/* sample_gain_square_moving_average_top.f */
rtl/sgsma_pkg.sv
rtl/sgsma_in_if.sv
rtl/sgsma_out_if.sv
rtl/sgsma_ram.sv
rtl/sgsma_mul.sv
rtl/sgsma_div.sv
rtl/sample_gain_square_moving_average_top.sv
verif/tb_sample_gain_square_moving_average_top.sv
